/* rtl/sstc_pkg.sv */
// shared types and constants for the span to slot chunker
package sstc_pkg;

   localparam int ADDR_W  = 64;
   localparam int LEN_W   = 32;
   localparam int REQ_W   = 16;
   localparam int SLOT_W  = 25;
   localparam int PLANS_W = 7;
   localparam int PIECE_W = 16;
   localparam int OFFS_W  = 24;

   localparam int CSR_W     = SLOT_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [SLOT_W-1:0]  SLOT_CAP    = 25'd16777216;
   localparam logic [SLOT_W-1:0]  SLOT_RESET  = 25'd65536;
   localparam logic [PLANS_W-1:0] PLANS_RESET = 7'd16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT_SIZE = 1'b0,
      CSR_MAX_PLANS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               first_span;
      logic [ADDR_W-1:0]  src_base;
      logic [ADDR_W-1:0]  dst_base;
      logic [LEN_W-1:0]   span_length;
      logic [REQ_W-1:0]   request_id;
      logic               span_error;
   } span_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [PLANS_W-1:0] plans;
   } limits_type;

endpackage

/* rtl/sstc_if.sv */
// span request and chunk response channel interfaces
interface sstc_req_if import sstc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               first_span;
   logic [ADDR_W-1:0]  src_base;
   logic [ADDR_W-1:0]  dst_base;
   logic [LEN_W-1:0]   span_length;
   logic [REQ_W-1:0]   request_id;

   modport source (output valid, first_span, src_base, dst_base, span_length, request_id,
                   input ready);
   modport sink   (input valid, first_span, src_base, dst_base, span_length, request_id,
                   output ready);
endinterface

interface sstc_rsp_if import sstc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  chunk_src;
   logic [ADDR_W-1:0]  chunk_dst;
   logic [SLOT_W-1:0]  chunk_length;
   logic [REQ_W-1:0]   chunk_request;
   logic [PIECE_W-1:0] piece_number;
   logic [OFFS_W-1:0]  offset_in_piece;
   logic               starts_piece;
   logic               span_error;
   logic               last_of_span;

   modport source (output valid, chunk_src, chunk_dst, chunk_length, chunk_request,
                   piece_number, offset_in_piece, starts_piece, span_error, last_of_span,
                   input ready);
   modport sink   (input valid, chunk_src, chunk_dst, chunk_length, chunk_request,
                   piece_number, offset_in_piece, starts_piece, span_error, last_of_span,
                   output ready);
endinterface

/* rtl/sstc_front.sv */
// span intake stage: range and length checks, registered toward the queue
module sstc_front import sstc_pkg::*; #(
   parameter int MAX_SLOTS_PER_SPAN = 62
) (
   input  logic              clock,
   input  logic              reset,
   sstc_req_if.sink          req_if,
   input  logic [SLOT_W-1:0] slot,
   output logic              fr_valid,
   output span_type          fr_span,
   input  logic              fr_ready
);

   localparam int CNT_W = $clog2(MAX_SLOTS_PER_SPAN + 1);
   localparam int LIM_W = CNT_W + SLOT_W;
   localparam int CMP_W = (LIM_W > LEN_W) ? LIM_W : LEN_W;

   logic             valid_ff;
   span_type         span_ff;
   span_type         span_in;
   logic             stage_free;
   logic [LEN_W-1:0] len_m1;
   logic [ADDR_W:0]  src_end;
   logic [ADDR_W:0]  dst_end;
   logic [CMP_W-1:0] limit;
   logic [CMP_W-1:0] len_w;

   assign stage_free   = !valid_ff || fr_ready;
   assign req_if.ready = stage_free;
   assign fr_valid     = valid_ff;
   assign fr_span      = span_ff;

   assign len_m1  = req_if.span_length - LEN_W'(1);
   assign src_end = {1'b0, req_if.src_base} + (ADDR_W+1)'(len_m1);
   assign dst_end = {1'b0, req_if.dst_base} + (ADDR_W+1)'(len_m1);
   assign limit   = CMP_W'(MAX_SLOTS_PER_SPAN) * CMP_W'(slot);
   assign len_w   = CMP_W'(req_if.span_length);

   always_comb begin
      span_in.first_span  = req_if.first_span;
      span_in.src_base    = req_if.src_base;
      span_in.dst_base    = req_if.dst_base;
      span_in.span_length = req_if.span_length;
      span_in.request_id  = req_if.request_id;
      span_in.span_error  = (req_if.span_length == '0) || src_end[ADDR_W] ||
                            dst_end[ADDR_W] || (len_w > limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_free) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_free && req_if.valid) begin
         span_ff <= span_in;
      end
   end

endmodule

/* rtl/sstc_queue.sv */
// short span queue between intake and chunk engine
module sstc_queue import sstc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  span_type push_span,
   output logic     push_ready,
   output logic     pop_valid,
   output span_type pop_span,
   input  logic     pop_ready
);

   span_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_span   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_span;
      end
   end

endmodule

/* rtl/sstc_back.sv */
// chunk engine: splits each accepted span into slot pieces, one chunk per cycle unless rsp_if stalls
module sstc_back import sstc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  limits_type limits,
   input  logic       q_valid,
   input  span_type   q_span,
   output logic       q_pop,
   sstc_rsp_if.source rsp_if
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  src_ff;
   logic [ADDR_W-1:0]  dst_ff;
   logic [LEN_W-1:0]   rem_ff;
   logic [REQ_W-1:0]   req_ff;
   logic [SLOT_W-1:0]  fill_ff;
   logic [PLANS_W-1:0] plans_ff;
   logic [PIECE_W-1:0] piece_ff;
   logic               open_ff;

   logic               out_valid_ff;
   logic [ADDR_W-1:0]  out_src_ff;
   logic [ADDR_W-1:0]  out_dst_ff;
   logic [SLOT_W-1:0]  out_len_ff;
   logic [REQ_W-1:0]   out_req_ff;
   logic [PIECE_W-1:0] out_piece_ff;
   logic [OFFS_W-1:0]  out_offs_ff;
   logic               out_starts_ff;
   logic               out_err_ff;
   logic               out_last_ff;

   logic               out_free;
   logic               out_load;
   logic               opening;
   logic [SLOT_W-1:0]  fill_base;
   logic [SLOT_W-1:0]  room;
   logic               fits;
   logic [SLOT_W-1:0]  take;
   logic [SLOT_W-1:0]  fill_in;
   logic [PLANS_W-1:0] plans_in;
   logic [PIECE_W-1:0] piece_in;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign opening   = !open_ff || (fill_ff >= limits.slot) || (plans_ff >= limits.plans);
   assign fill_base = opening ? '0 : fill_ff;
   assign room      = limits.slot - fill_base;
   assign fits      = (rem_ff <= LEN_W'(room));
   assign take      = fits ? rem_ff[SLOT_W-1:0] : room;
   assign fill_in   = fill_base + take;
   assign plans_in  = (opening ? '0 : plans_ff) + PLANS_W'(1);
   assign piece_in  = !opening ? piece_ff : (open_ff ? piece_ff + PIECE_W'(1) : '0);
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && out_free;
   assign out_load  = (q_pop && q_span.span_error) || ((state_ff == ST_RUN) && out_free);

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.chunk_src       = out_src_ff;
   assign rsp_if.chunk_dst       = out_dst_ff;
   assign rsp_if.chunk_length    = out_len_ff;
   assign rsp_if.chunk_request   = out_req_ff;
   assign rsp_if.piece_number    = out_piece_ff;
   assign rsp_if.offset_in_piece = out_offs_ff;
   assign rsp_if.starts_piece    = out_starts_ff;
   assign rsp_if.span_error      = out_err_ff;
   assign rsp_if.last_of_span    = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         fill_ff      <= '0;
         plans_ff     <= '0;
         piece_ff     <= '0;
         open_ff      <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (q_span.span_error) begin
                     out_src_ff    <= q_span.src_base;
                     out_dst_ff    <= q_span.dst_base;
                     out_len_ff    <= '0;
                     out_req_ff    <= q_span.request_id;
                     out_piece_ff  <= piece_ff;
                     out_offs_ff   <= '0;
                     out_starts_ff <= 1'b0;
                     out_err_ff    <= 1'b1;
                     out_last_ff   <= 1'b1;
                  end else begin
                     src_ff   <= q_span.src_base;
                     dst_ff   <= q_span.dst_base;
                     rem_ff   <= q_span.span_length;
                     req_ff   <= q_span.request_id;
                     state_ff <= ST_RUN;
                     if (q_span.first_span) begin
                        open_ff <= 1'b0;
                     end
                  end
               end
            end
            ST_RUN: begin
               if (out_free) begin
                  out_src_ff    <= src_ff;
                  out_dst_ff    <= dst_ff;
                  out_len_ff    <= take;
                  out_req_ff    <= req_ff;
                  out_piece_ff  <= piece_in;
                  out_offs_ff   <= fill_base[OFFS_W-1:0];
                  out_starts_ff <= opening;
                  out_err_ff    <= 1'b0;
                  out_last_ff   <= fits;
                  src_ff        <= src_ff + ADDR_W'(take);
                  dst_ff        <= dst_ff + ADDR_W'(take);
                  rem_ff        <= rem_ff - LEN_W'(take);
                  fill_ff       <= fill_in;
                  plans_ff      <= plans_in;
                  piece_ff      <= piece_in;
                  open_ff       <= 1'b1;
                  if (fits) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/span_to_slot_chunker.sv */
// top level of the span to slot chunker
//
//   channel   dir  handshake           carries
//   req_if    in   valid/ready         one transfer span per item
//   rsp_if    out  valid/ready         one chunk or one error result per item
//   csr_*     in   csr_we, no wait     slot_size (index 0), max_plans (index 1)
//
// a span is first loaded into the chunk engine, which then gives one chunk per cycle
// while the output is not stalled; a rejected span gives one error result from idle
// the intake stage is registered and a two-item queue sits ahead of the engine
// reset is synchronous: slot_size 65536, max_plans 16, no piece open
// either side may stall; the output register holds a chunk until rsp_if.ready
module span_to_slot_chunker import sstc_pkg::*; #(
   parameter int MAX_PLANS_LIMIT    = 64,
   parameter int MAX_SLOTS_PER_SPAN = 62
) (
   input  logic                 clock,
   input  logic                 reset,
   sstc_req_if.sink             req_if,
   sstc_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [SLOT_W-1:0]  slot_ff;
   logic [PLANS_W-1:0] plans_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic [PLANS_W-1:0] plans_raw;
   logic [PLANS_W-1:0] plans_in;
   limits_type         limits;

   logic               fr_valid;
   span_type           fr_span;
   logic               fr_ready;
   logic               q_valid;
   span_type           q_span;
   logic               q_pop;

   assign slot_in   = (csr_wdata == '0) ? SLOT_W'(1) :
                      (csr_wdata > SLOT_CAP) ? SLOT_CAP : csr_wdata;
   assign plans_raw = csr_wdata[PLANS_W-1:0];
   assign plans_in  = (plans_raw == '0) ? PLANS_W'(1) :
                      (plans_raw > PLANS_W'(MAX_PLANS_LIMIT)) ? PLANS_W'(MAX_PLANS_LIMIT) :
                      plans_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_RESET;
         plans_ff <= PLANS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLOT_SIZE: slot_ff  <= slot_in;
            CSR_MAX_PLANS: plans_ff <= plans_in;
            default: begin
            end
         endcase
      end
   end

   assign limits.slot  = slot_ff;
   assign limits.plans = plans_ff;

   sstc_front #(
      .MAX_SLOTS_PER_SPAN(MAX_SLOTS_PER_SPAN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .slot     (slot_ff),
      .fr_valid (fr_valid),
      .fr_span  (fr_span),
      .fr_ready (fr_ready)
   );

   sstc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_span  (fr_span),
      .push_ready (fr_ready),
      .pop_valid  (q_valid),
      .pop_span   (q_span),
      .pop_ready  (q_pop)
   );

   sstc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .limits  (limits),
      .q_valid (q_valid),
      .q_span  (q_span),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

/* rtl/sstc_checker.sv */
// port-level checks on the chunk response channel, bound to the top level
module sstc_checker import sstc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SLOT_W-1:0] chunk_length,
   input logic [OFFS_W-1:0] offset_in_piece,
   input logic              starts_piece,
   input logic              span_error,
   input logic              last_of_span
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(chunk_length) &&
      $stable(span_error) && $stable(last_of_span))
      else $error("stalled item changed or dropped");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && span_error |-> chunk_length == '0 && last_of_span &&
      !starts_piece && offset_in_piece == '0)
      else $error("malformed error item");

   a_chunk_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !span_error |-> chunk_length != '0 &&
      (!starts_piece || offset_in_piece == '0))
      else $error("malformed chunk item");

endmodule

bind span_to_slot_chunker sstc_checker u_sstc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .chunk_length    (rsp_if.chunk_length),
   .offset_in_piece (rsp_if.offset_in_piece),
   .starts_piece    (rsp_if.starts_piece),
   .span_error      (rsp_if.span_error),
   .last_of_span    (rsp_if.last_of_span)
);

/* tb/sv/tb.sv */
// testbench for span_to_slot_chunker: directed and random spans checked against a chunk predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sstc_pkg::*;

   localparam int MAX_PLANS_LIMIT    = 64;
   localparam int MAX_SLOTS_PER_SPAN = 62;
   localparam int IDLE_PCT           = 30;
   localparam int LIMIT_CYCLES       = 1000000;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

   typedef struct packed {
      logic              first_span;
      logic [ADDR_W-1:0] src_base;
      logic [ADDR_W-1:0] dst_base;
      logic [LEN_W-1:0]  span_length;
      logic [REQ_W-1:0]  request_id;
   } span_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  chunk_src;
      logic [ADDR_W-1:0]  chunk_dst;
      logic [SLOT_W-1:0]  chunk_length;
      logic [REQ_W-1:0]   chunk_request;
      logic [PIECE_W-1:0] piece_number;
      logic [OFFS_W-1:0]  offset_in_piece;
      logic               starts_piece;
      logic               span_error;
      logic               last_of_span;
   } chunk_item_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   sstc_req_if req_if ();
   sstc_rsp_if rsp_if ();

   span_to_slot_chunker dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   span_item_type  span_queue[$];
   chunk_item_type chunk_expect[$];
   int             spans_pushed   = 0;
   int             spans_taken    = 0;
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   bit             steady         = 1'b0;
   logic           req_took       = 1'b0;

   // block registers and piece state as the predictor sees them
   logic [SLOT_W-1:0]  slot_size_reg = SLOT_RESET;
   logic [PLANS_W-1:0] max_plans_reg = PLANS_RESET;
   logic [SLOT_W-1:0]  fill_bytes    = '0;
   logic [PLANS_W-1:0] plans_used    = '0;
   logic [PIECE_W-1:0] piece_count   = '0;
   logic               piece_live    = 1'b0;

   function automatic logic [SLOT_W-1:0] eff_slot();
      if (slot_size_reg == '0) return SLOT_W'(1);
      if (slot_size_reg > SLOT_CAP) return SLOT_CAP;
      return slot_size_reg;
   endfunction

   function automatic void split_span(input span_item_type s);
      logic [SLOT_W-1:0]  slot;
      logic [PLANS_W-1:0] plans;
      logic [ADDR_W:0]    src_last;
      logic [ADDR_W:0]    dst_last;
      logic [LEN_W-1:0]   done;
      logic [LEN_W-1:0]   take;
      logic [LEN_W-1:0]   room;
      logic               starts;
      chunk_item_type     c;
      slot = eff_slot();
      if (max_plans_reg == '0) plans = PLANS_W'(1);
      else if (max_plans_reg > MAX_PLANS_LIMIT) plans = PLANS_W'(MAX_PLANS_LIMIT);
      else plans = max_plans_reg;
      src_last = {1'b0, s.src_base} + s.span_length - 1;
      dst_last = {1'b0, s.dst_base} + s.span_length - 1;
      c.chunk_request = s.request_id;
      if (s.span_length == '0 || src_last[ADDR_W] || dst_last[ADDR_W] ||
          64'(s.span_length) > 64'(MAX_SLOTS_PER_SPAN) * 64'(slot)) begin
         c.chunk_src       = s.src_base;
         c.chunk_dst       = s.dst_base;
         c.chunk_length    = '0;
         c.piece_number    = piece_count;
         c.offset_in_piece = '0;
         c.starts_piece    = 1'b0;
         c.span_error      = 1'b1;
         c.last_of_span    = 1'b1;
         chunk_expect = {chunk_expect, c};
         return;
      end
      if (s.first_span) piece_live = 1'b0;
      done = '0;
      while (done < s.span_length) begin
         starts = 1'b0;
         if (!piece_live || fill_bytes >= slot || plans_used >= plans) begin
            piece_count = piece_live ? piece_count + 1'b1 : '0;
            piece_live  = 1'b1;
            fill_bytes  = '0;
            plans_used  = '0;
            starts      = 1'b1;
         end
         room = LEN_W'(slot - fill_bytes);
         take = (s.span_length - done > room) ? room : s.span_length - done;
         c.chunk_src       = s.src_base + done;
         c.chunk_dst       = s.dst_base + done;
         c.chunk_length    = take[SLOT_W-1:0];
         c.piece_number    = piece_count;
         c.offset_in_piece = fill_bytes[OFFS_W-1:0];
         c.starts_piece    = starts;
         c.span_error      = 1'b0;
         c.last_of_span    = (done + take >= s.span_length);
         chunk_expect = {chunk_expect, c};
         fill_bytes = fill_bytes + take[SLOT_W-1:0];
         plans_used = plans_used + 1'b1;
         done       = done + take;
      end
   endfunction

   function automatic void queue_span(input logic first, input logic [ADDR_W-1:0] src,
                                      input logic [ADDR_W-1:0] dst,
                                      input logic [LEN_W-1:0] len,
                                      input logic [REQ_W-1:0] req);
      span_item_type s;
      s.first_span  = first;
      s.src_base    = src;
      s.dst_base    = dst;
      s.span_length = len;
      s.request_id  = req;
      span_queue = {span_queue, s};
      spans_pushed++;
   endfunction

   function automatic void queue_random_span();
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  limit;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      int unsigned       roll;
      slot  = eff_slot();
      limit = MAX_SLOTS_PER_SPAN * slot;
      roll  = $urandom_range(99);
      if (roll < 5) len = '0;
      else if (roll < 10) len = $urandom;
      else if (roll < 14) len = limit + $urandom_range(3, 1);
      else if (roll < 70) len = $urandom_range(3 * slot, 1);
      else len = $urandom_range(limit, 1);
      src  = {$urandom, $urandom};
      dst  = {$urandom, $urandom};
      roll = $urandom_range(99);
      // place the span around the top of the address space
      if (roll < 8) src = ADDR_TOP - (64'(len) - 64'($urandom_range(2)));
      else if (roll < 16) dst = ADDR_TOP - (64'(len) - 64'($urandom_range(2)));
      queue_span($urandom_range(99) < 20, src, dst, len, 16'($urandom_range(65535)));
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_SLOT_SIZE) slot_size_reg = value;
      else max_plans_reg = value[PLANS_W-1:0];
   endtask

   task automatic set_limits(input logic [CSR_W-1:0] slot, input logic [CSR_W-1:0] plans);
      write_csr(CSR_SLOT_SIZE, slot);
      write_csr(CSR_MAX_PLANS, plans);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (spans_taken != spans_pushed || chunk_expect.size() != 0);
   endtask

   task automatic random_phase(input int count);
      repeat (count) queue_random_span();
      drain();
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // item driver
   always @(negedge clock) begin : feed
      span_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (span_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = span_queue.pop_front();
            req_if.valid       <= 1'b1;
            req_if.first_span  <= nxt.first_span;
            req_if.src_base    <= nxt.src_base;
            req_if.dst_base    <= nxt.dst_base;
            req_if.span_length <= nxt.span_length;
            req_if.request_id  <= nxt.request_id;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // monitor
   always @(posedge clock) begin : watch
      span_item_type  got;
      chunk_item_type want;
      req_took <= req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         got.first_span  = req_if.first_span;
         got.src_base    = req_if.src_base;
         got.dst_base    = req_if.dst_base;
         got.span_length = req_if.span_length;
         got.request_id  = req_if.request_id;
         split_span(got);
         spans_taken++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (chunk_expect.size() == 0) begin
            $display("%0t: unexpected item, expected none actual src %0h length %0h",
                     $time, rsp_if.chunk_src, rsp_if.chunk_length);
            mismatch_count++;
         end else begin
            want = chunk_expect.pop_front();
            check_field("chunk_src", want.chunk_src, rsp_if.chunk_src);
            check_field("chunk_dst", want.chunk_dst, rsp_if.chunk_dst);
            check_field("chunk_length", 64'(want.chunk_length),
                        64'(rsp_if.chunk_length));
            check_field("chunk_request", 64'(want.chunk_request),
                        64'(rsp_if.chunk_request));
            check_field("piece_number", 64'(want.piece_number),
                        64'(rsp_if.piece_number));
            check_field("offset_in_piece", 64'(want.offset_in_piece),
                        64'(rsp_if.offset_in_piece));
            check_field("starts_piece", 64'(want.starts_piece),
                        64'(rsp_if.starts_piece));
            check_field("span_error", 64'(want.span_error), 64'(rsp_if.span_error));
            check_field("last_of_span", 64'(want.last_of_span),
                        64'(rsp_if.last_of_span));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_SLOT_SIZE;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.first_span  = 1'b0;
      req_if.src_base    = '0;
      req_if.dst_base    = '0;
      req_if.span_length = '0;
      req_if.request_id  = '0;
      rsp_if.ready       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset limits: slot 65536, 16 plans
      queue_span(1'b0, '0, '0, 32'd1, 16'h0000);
      queue_span(1'b1, ADDR_TOP, ADDR_TOP, 32'd0, 16'hFFFF);
      queue_span(1'b0, ADDR_TOP, 64'd0, 32'd1, 16'h1234);
      queue_span(1'b0, ADDR_TOP, 64'd5, 32'd2, 16'h0002);
      queue_span(1'b0, 64'd1000, ADDR_TOP - 1, 32'd3, 16'h0003);
      queue_span(1'b0, 64'd0, ADDR_TOP - 1, 32'd2, 16'h0004);
      queue_span(1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd4063232,
                 16'h0007);
      queue_span(1'b0, 64'd0, 64'd0, 32'd4063233, 16'h0008);
      queue_span(1'b0, 64'd0, 64'd0, 32'hFFFF_FFFF, 16'h0009);
      drain();

      set_limits(25'd3, 25'd2);
      queue_span(1'b1, 64'd100, 64'd200, 32'd1, 16'h0010);
      queue_span(1'b0, 64'd101, 64'd201, 32'd1, 16'h0011);
      queue_span(1'b0, 64'd102, 64'd202, 32'd1, 16'h0012);
      queue_span(1'b0, 64'd103, 64'd203, 32'd5, 16'h0013);
      queue_span(1'b0, 64'd200, 64'd300, 32'd186, 16'h0014);
      queue_span(1'b0, 64'd200, 64'd300, 32'd187, 16'h0015);
      drain();

      // zero registers act as one
      set_limits(25'd0, 25'd0);
      queue_span(1'b0, 64'd7, 64'd9, 32'd62, 16'h0020);
      queue_span(1'b0, 64'd7, 64'd9, 32'd63, 16'h0021);
      queue_span(1'b1, 64'd7, 64'd9, 32'd2, 16'h0022);
      drain();

      // oversized registers clamp to the caps
      set_limits('1, 25'd127);
      queue_span(1'b1, 64'h1000, 64'h2000, 32'd1040187392, 16'h0030);
      queue_span(1'b0, 64'h1000, 64'h2000, 32'd1040187393, 16'h0031);
      queue_span(1'b0, 64'h5000, 64'h6000, 32'd1000, 16'h0032);
      queue_span(1'b0, 64'h9000, 64'hA000, 32'd5000000, 16'h0033);
      drain();

      // slot shrinks below the open piece's fill
      set_limits(25'd16, 25'd64);
      queue_span(1'b0, 64'hBEEF, 64'hCAFE, 32'd20, 16'h0040);
      drain();

      // one-byte pieces back to back with no idling
      set_limits(25'd1, 25'd1);
      steady = 1'b1;
      for (int i = 0; i < 4; i++) begin
         queue_span(i == 0, 64'(i) * 62, 64'(i) * 62 + 64'h8000_0000, 32'd62, 16'(i));
      end
      drain();
      steady = 1'b0;

      set_limits(CSR_W'($urandom_range(200, 1)), CSR_W'($urandom_range(8, 1)));
      random_phase(25);
      set_limits(CSR_W'($urandom), CSR_W'($urandom));
      random_phase(25);
      set_limits(SLOT_CAP, 25'(MAX_PLANS_LIMIT));
      random_phase(25);
      set_limits(CSR_W'($urandom_range(5000, 1)),
                 CSR_W'($urandom_range(MAX_PLANS_LIMIT, 1)));
      random_phase(30);

      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
